// ===== src/assert_macros.svh =====
// assertion macros for the knight search rtl
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define KM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("knight search assertion failed");
`define KM_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("knight search forbidden condition");
`else
`define KM_ASSERT(lbl, prop)
`define KM_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== src/kmm_pkg.sv =====
// shared types and constants for the knight shortest-path search
// no dependencies
package kmm_pkg;

  localparam int KM_MAX_DIM = 64;
  localparam int ROWS_W     = 7;
  localparam int COORD_IN_W = 6;
  localparam int DIST_W     = 12;
  localparam logic [DIST_W-1:0] DIST_MAX = 12'hFFF;
  localparam int JUMP_N     = 8;

  localparam logic signed [2:0] JUMP_DR [0:JUMP_N-1] =
    '{3'sd1, 3'sd1, -3'sd1, -3'sd1, 3'sd2, 3'sd2, -3'sd2, -3'sd2};
  localparam logic signed [2:0] JUMP_DC [0:JUMP_N-1] =
    '{3'sd2, -3'sd2, 3'sd2, -3'sd2, 3'sd1, -3'sd1, 3'sd1, -3'sd1};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEED,
    ST_FETCH,
    ST_SCAN,
    ST_DRAIN,
    ST_LOOKUP,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic seed;
    logic fetch;
    logic scan;
    logic lookup;
    logic reply;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_in;
    logic clr_last;
    logic k_last;
    logic empty;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== src/kmm_ctrl.sv =====
// sequencer for the knight search: clear, seed, fetch/scan loop, lookup, reply
// depends on kmm_pkg
module kmm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kmm_pkg::dp_stat_t  stat,
  output kmm_pkg::dp_cmd_t   cmd
);
  import kmm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.bad_in ? ST_REPLY : ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (stat.clr_last) begin
          state_nxt = ST_SEED;
        end
      end
      ST_SEED:  state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = stat.empty ? ST_LOOKUP : ST_SCAN;
      ST_SCAN: begin
        if (stat.k_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_nxt = ST_FETCH;
      ST_LOOKUP: state_nxt = ST_REPLY;
      ST_REPLY: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_CLEAR:  cmd.clear  = 1'b1;
      ST_SEED:   cmd.seed   = 1'b1;
      ST_FETCH:  cmd.fetch  = !stat.empty;
      ST_SCAN:   cmd.scan   = 1'b1;
      ST_DRAIN:  cmd        = '0;
      ST_LOOKUP: cmd.lookup = 1'b1;
      ST_REPLY:  cmd.reply  = stat.out_free;
      default:   cmd        = '0;
    endcase
  end

endmodule

// ===== src/kmm_datapath.sv =====
// datapath of the knight search: square map, square queue, move generator, output register
// depends on kmm_pkg and assert_macros.svh
`include "assert_macros.svh"
module kmm_datapath #(
  parameter int MAX_DIM = kmm_pkg::KM_MAX_DIM
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kmm_pkg::dp_cmd_t                cmd,
  output kmm_pkg::dp_stat_t               stat,
  input  logic [kmm_pkg::ROWS_W-1:0]      in_grid_rows,
  input  logic [kmm_pkg::ROWS_W-1:0]      in_grid_cols,
  input  logic [kmm_pkg::COORD_IN_W-1:0]  in_src_row,
  input  logic [kmm_pkg::COORD_IN_W-1:0]  in_src_col,
  input  logic [kmm_pkg::COORD_IN_W-1:0]  in_dst_row,
  input  logic [kmm_pkg::COORD_IN_W-1:0]  in_dst_col,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_reachable,
  output logic [kmm_pkg::DIST_W-1:0]      out_move_count,
  output logic                            out_bad_coords
);
  import kmm_pkg::*;

  localparam int COORD_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int POS_W   = 2 * COORD_W;
  localparam int DEPTH   = 1 << POS_W;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int SW      = DIM_W + 2;
  localparam int CMP_W   = (DIM_W > ROWS_W) ? DIM_W : ROWS_W;
  localparam int ENT_W   = POS_W + DIST_W;
  localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_DIM);

  // query capture
  logic [CMP_W-1:0] rows_cl;
  logic [CMP_W-1:0] cols_cl;
  logic             bad_in;
  logic [DIM_W-1:0] rows_r;
  logic [DIM_W-1:0] cols_r;
  logic [POS_W-1:0] src_pos_r;
  logic [POS_W-1:0] dst_pos_r;
  logic             bad_r;

  assign rows_cl = (CMP_W'(in_grid_rows) > MAX_W) ? MAX_W : CMP_W'(in_grid_rows);
  assign cols_cl = (CMP_W'(in_grid_cols) > MAX_W) ? MAX_W : CMP_W'(in_grid_cols);
  assign bad_in  = (CMP_W'(in_src_row) >= rows_cl) || (CMP_W'(in_src_col) >= cols_cl) ||
                   (CMP_W'(in_dst_row) >= rows_cl) || (CMP_W'(in_dst_col) >= cols_cl);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rows_r    <= DIM_W'(rows_cl);
      cols_r    <= DIM_W'(cols_cl);
      src_pos_r <= {COORD_W'(in_src_row), COORD_W'(in_src_col)};
      dst_pos_r <= {COORD_W'(in_dst_row), COORD_W'(in_dst_col)};
      bad_r     <= bad_in;
    end
  end

  // counters and queue pointers
  logic [POS_W-1:0] clr_cnt_r;
  logic [2:0]       k_r;
  logic [POS_W:0]   head_r;
  logic [POS_W:0]   tail_r;
  logic             chk_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      k_r       <= '0;
      head_r    <= '0;
      tail_r    <= '0;
    end else begin
      if (cmd.capture) begin
        clr_cnt_r <= '0;
      end else if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + POS_W'(1);
      end
      if (cmd.fetch) begin
        k_r <= '0;
      end else if (cmd.scan) begin
        k_r <= k_r + 3'd1;
      end
      if (cmd.seed) begin
        head_r <= '0;
      end else if (cmd.fetch) begin
        head_r <= head_r + (POS_W+1)'(1);
      end
      if (cmd.seed) begin
        tail_r <= (POS_W+1)'(1);
      end else if (chk_wr) begin
        tail_r <= tail_r + (POS_W+1)'(1);
      end
    end
  end

  // square queue: position and distance
  logic [ENT_W-1:0] fifo_mem [DEPTH];
  logic [ENT_W-1:0] fifo_rd_r;
  logic             fifo_we;
  logic [POS_W-1:0] fifo_wa;
  logic [ENT_W-1:0] fifo_wd;

  logic [POS_W-1:0]  chk_pos_r;
  logic [DIST_W-1:0] chk_dist_r;
  logic              chk_v_r;

  assign fifo_we = cmd.seed || chk_wr;
  assign fifo_wa = cmd.seed ? '0 : tail_r[POS_W-1:0];
  assign fifo_wd = cmd.seed ? {src_pos_r, {DIST_W{1'b0}}} : {chk_pos_r, chk_dist_r};

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_wa] <= fifo_wd;
    end
    if (cmd.fetch) begin
      fifo_rd_r <= fifo_mem[head_r[POS_W-1:0]];
    end
  end

  // move generator
  logic [POS_W-1:0]   cur_pos;
  logic [DIST_W-1:0]  cur_dist;
  logic [COORD_W-1:0] cur_row;
  logic [COORD_W-1:0] cur_col;
  logic signed [SW-1:0] nr_s;
  logic signed [SW-1:0] nc_s;
  logic               inb;
  logic [POS_W-1:0]   nb_pos;
  logic [DIST_W-1:0]  nb_dist;

  assign cur_pos  = fifo_rd_r[ENT_W-1:DIST_W];
  assign cur_dist = fifo_rd_r[DIST_W-1:0];
  assign cur_row  = cur_pos[POS_W-1:COORD_W];
  assign cur_col  = cur_pos[COORD_W-1:0];
  assign nr_s     = $signed(SW'(cur_row)) + SW'(JUMP_DR[k_r]);
  assign nc_s     = $signed(SW'(cur_col)) + SW'(JUMP_DC[k_r]);
  assign inb      = !nr_s[SW-1] && !nc_s[SW-1] &&
                    (nr_s < $signed(SW'(rows_r))) && (nc_s < $signed(SW'(cols_r)));
  assign nb_pos   = {nr_s[COORD_W-1:0], nc_s[COORD_W-1:0]};
  assign nb_dist  = (cur_dist == DIST_MAX) ? cur_dist : cur_dist + DIST_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_v_r <= 1'b0;
    end else begin
      chk_v_r <= cmd.scan && inb;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      chk_pos_r  <= nb_pos;
      chk_dist_r <= nb_dist;
    end
  end

  // square map: seen bit and distance
  logic [DIST_W:0]   map_mem [DEPTH];
  logic [DIST_W:0]   map_rd_r;
  logic              map_re;
  logic [POS_W-1:0]  map_ra;
  logic              map_we;
  logic [POS_W-1:0]  map_wa;
  logic [DIST_W:0]   map_wd;

  assign chk_wr = chk_v_r && !map_rd_r[DIST_W];
  assign map_re = (cmd.scan && inb) || cmd.lookup;
  assign map_ra = cmd.lookup ? dst_pos_r : nb_pos;
  assign map_we = cmd.clear || cmd.seed || chk_wr;

  always_comb begin
    map_wa = chk_pos_r;
    map_wd = {1'b1, chk_dist_r};
    priority if (cmd.clear) begin
      map_wa = clr_cnt_r;
      map_wd = '0;
    end else if (cmd.seed) begin
      map_wa = src_pos_r;
      map_wd = {1'b1, {DIST_W{1'b0}}};
    end else begin
      map_wa = chk_pos_r;
      map_wd = {1'b1, chk_dist_r};
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (map_re) begin
      map_rd_r <= map_mem[map_ra];
    end
  end

  // output register
  logic              out_valid_r;
  logic              out_reach_r;
  logic [DIST_W-1:0] out_count_r;
  logic              out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.reply) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reply) begin
      out_bad_r   <= bad_r;
      out_reach_r <= !bad_r && map_rd_r[DIST_W];
      out_count_r <= (!bad_r && map_rd_r[DIST_W]) ? map_rd_r[DIST_W-1:0] : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reachable  = out_reach_r;
  assign out_move_count = out_count_r;
  assign out_bad_coords = out_bad_r;

  assign stat.bad_in   = bad_in;
  assign stat.clr_last = &clr_cnt_r;
  assign stat.k_last   = &k_r;
  assign stat.empty    = (head_r == tail_r);
  assign stat.out_free = !out_valid_r || !out_stall;

  `KM_ASSERT_NEVER(a_head_past_tail, head_r > tail_r)
  `KM_ASSERT(a_tail_bound, tail_r <= (POS_W+1)'(DEPTH))
  `KM_ASSERT(a_chk_after_scan, chk_v_r |-> $past(cmd.scan))
  `KM_ASSERT(a_reply_when_free, cmd.reply |-> (!out_valid_r || !out_stall))
  `KM_ASSERT(a_one_writer, $onehot0({cmd.clear, cmd.seed, chk_wr}))

endmodule

// ===== src/knight_min_moves_bfs.sv =====
// knight shortest-path search, one query at a time
// with valid coordinates a query clears the whole map (DEPTH squares, 4096 at 64x64),
// seeds the source, then reads each queued square, tries its eight knight moves and
// drains the last check before the next read, then looks up the destination; bad coordinates go straight to the reply
// a new query is accepted once the result is in the output register
// reset (synchronous, active low) idles the sequencer and empties queue and output
module knight_min_moves_bfs #(
  parameter int MAX_DIM = kmm_pkg::KM_MAX_DIM
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kmm_pkg::ROWS_W-1:0]      in_grid_rows,
  input  logic [kmm_pkg::ROWS_W-1:0]      in_grid_cols,
  input  logic [kmm_pkg::COORD_IN_W-1:0]  in_src_row,
  input  logic [kmm_pkg::COORD_IN_W-1:0]  in_src_col,
  input  logic [kmm_pkg::COORD_IN_W-1:0]  in_dst_row,
  input  logic [kmm_pkg::COORD_IN_W-1:0]  in_dst_col,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_reachable,
  output logic [kmm_pkg::DIST_W-1:0]      out_move_count,
  output logic                            out_bad_coords
);
  import kmm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  kmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  kmm_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_grid_rows   (in_grid_rows),
    .in_grid_cols   (in_grid_cols),
    .in_src_row     (in_src_row),
    .in_src_col     (in_src_col),
    .in_dst_row     (in_dst_row),
    .in_dst_col     (in_dst_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_reachable  (out_reachable),
    .out_move_count (out_move_count),
    .out_bad_coords (out_bad_coords)
  );

endmodule
